// File: rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  // Default geometry of the occupancy map.
  localparam int unsigned BLOCK_TOTAL_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF   = 32;

  // Fixed widths of the transaction fields.
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned WIDX_W   = 5;
  localparam int unsigned WDATA_W  = 32;
  localparam int unsigned BLKIDX_W = 10;
  localparam int unsigned BLKCNT_W = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_READ   = 3'd1,
    OP_FIRST  = 3'd2,
    OP_CONTIG = 3'd3,
    OP_COUNT  = 3'd4,
    OP_GROW   = 3'd5
  } bba_op_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [WIDX_W-1:0]   word_index;
    logic [WDATA_W-1:0]  word_data;
    logic [BLKIDX_W-1:0] start_block;
    logic [BLKCNT_W-1:0] blocks_needed;
    logic [BLKCNT_W-1:0] blocks_held;
  } bba_in_t;

  typedef struct packed {
    logic                found;
    logic [BLKIDX_W-1:0] block_index;
    logic [BLKCNT_W-1:0] free_count;
    logic [WDATA_W-1:0]  word_out;
  } bba_out_t;

  // Control from the sequencer to the scan datapath.
  typedef struct packed {
    logic init;        // Clear the scan accumulators.
    logic word_valid;  // A map word is present on the read data this cycle.
    logic widx_ok;     // The command's word index names a map word.
  } bba_scan_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } bba_state_e;

endpackage

`default_nettype wire

// File: rtl/block_bitmap_allocator.sv
// Block occupancy bitmap allocator. The map holds one bit per storage block,
// bit i mod WORD_BITS of word i/WORD_BITS, and a set bit means the block is
// used. Each input transaction is one command (load or read a map word, find
// the first free block, count free blocks, contiguous fit, grow fit) and
// yields exactly one output transaction. The map sits in a single-port
// synchronous RAM. A load or a read passes through acceptance, the RAM access
// and the result state, and its result is registered as it leaves the result
// state. The search and count commands read every map word once in order, one
// word per cycle, then evaluate the last word and register their result.
// Commands are handled one at a time, but a new command is accepted while the
// previous result still waits in the output register. A finished result that
// finds the output register still full and stalled waits until that register
// is taken, which adds the output stall to the command's time. After reset the
// block clears the RAM, one word per cycle, and holds in_stall_o high until
// every word has been cleared.

`default_nettype none

module block_bitmap_allocator import bba_pkg::*; #(
  parameter int unsigned BLOCK_TOTAL = BLOCK_TOTAL_DEF,
  parameter int unsigned WORD_BITS   = WORD_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,

  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire bba_in_t  in_data_i,

  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output bba_out_t      out_data_o
);

  localparam int unsigned MAP_WORDS = (BLOCK_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  bba_state_e state_q, state_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          rd_vld_q, rd_vld_d;
  bba_in_t       cmd_q;
  logic          out_valid_q, out_valid_d;
  bba_out_t      out_q;

  logic in_accept;
  logic out_load;
  logic widx_ok;

  assign in_accept = in_valid_i && !in_stall_o;
  assign widx_ok   = (32'(cmd_q.word_index) < 32'(MAP_WORDS));

  // The command is captured once per transaction and held until its result
  // has been handed to the output register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= in_data_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (ptr_q == LAST_WORD) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (cmd_q.opcode inside {OP_FIRST, OP_CONTIG, OP_COUNT, OP_GROW}) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (ptr_q == LAST_WORD) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // RAM access and sequencer outputs.
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  bba_scan_ctrl_t       scan_ctrl;

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = ptr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = ptr_q;
    ptr_d      = ptr_q;
    rd_vld_d   = 1'b0;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    scan_ctrl  = '0;
    case (state_q)
      ST_CLEAR: begin
        // Power-up sweep: every map word starts out free.
        mem_we = 1'b1;
        ptr_d  = (ptr_q == LAST_WORD) ? '0 : ptr_q + AW'(1);
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_START: begin
        scan_ctrl.init = 1'b1;
        ptr_d          = '0;
        if (cmd_q.opcode == OP_LOAD && widx_ok) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cmd_q.word_index);
          mem_wdata = WORD_BITS'(cmd_q.word_data);
        end
        if (cmd_q.opcode == OP_READ && widx_ok) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(cmd_q.word_index);
        end
      end
      ST_SCAN: begin
        // One word per cycle; its data is evaluated in the following cycle.
        mem_re   = 1'b1;
        rd_vld_d = 1'b1;
        ptr_d    = (ptr_q == LAST_WORD) ? '0 : ptr_q + AW'(1);
      end
      ST_TAIL: begin
        // Only the last word's evaluation is left.
      end
      ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    scan_ctrl.word_valid = rd_vld_q;
    scan_ctrl.widx_ok    = widx_ok;
  end

  // Occupancy map storage with registered read data.
  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  bba_out_t scan_res;

  bba_scan #(
    .BLOCK_TOTAL (BLOCK_TOTAL),
    .WORD_BITS   (WORD_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .cmd_i  (cmd_q),
    .word_i (rdata_q),
    .res_o  (scan_res)
  );

  // Output register: it frees the command path while the result waits.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= scan_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/bba_scan.sv
`default_nettype none

module bba_scan import bba_pkg::*; #(
  parameter int unsigned BLOCK_TOTAL = BLOCK_TOTAL_DEF,
  parameter int unsigned WORD_BITS   = WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bba_scan_ctrl_t       ctrl_i,
  input  wire bba_in_t              cmd_i,
  input  wire logic [WORD_BITS-1:0] word_i,
  output bba_out_t                  res_o
);

  // Block numbers, run lengths and range bounds all share one width that holds
  // the map size plus one word as well as start_block + blocks_needed.
  localparam int unsigned BTW = $clog2(BLOCK_TOTAL + WORD_BITS + 1);
  localparam int unsigned CW  = (BTW > 12) ? BTW : 12;
  localparam int unsigned IW  = $clog2(WORD_BITS);
  localparam int unsigned PW  = $clog2(WORD_BITS + 1);

  logic [CW-1:0] base_q, base_d;
  logic [CW-1:0] run_q, run_d;
  logic          ff_found_q, ff_found_d;
  logic [CW-1:0] ff_at_q, ff_at_d;
  logic          clean_q, clean_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic [CW-1:0] start_w, need_w, held_w, need_ff;
  logic [CW-1:0] force_hi, rng_lo, rng_hi;
  logic          is_grow;

  assign start_w  = CW'(cmd_i.start_block);
  assign need_w   = CW'(cmd_i.blocks_needed);
  assign held_w   = CW'(cmd_i.blocks_held);
  assign is_grow  = (cmd_i.opcode == OP_GROW);
  // First free block is a first fit of a single block.
  assign need_ff  = (cmd_i.opcode == OP_FIRST) ? CW'(1) : need_w;
  // The file's own blocks count as free only for a grow.
  assign force_hi = is_grow ? (start_w + held_w) : start_w;
  assign rng_lo   = is_grow ? (start_w + held_w) : start_w;
  assign rng_hi   = start_w + need_w;

  logic [WORD_BITS-1:0] used_raw, used_ff, rng_mask;
  logic                 hit;
  logic [IW-1:0]        hit_pos;
  logic [CW-1:0]        run_out;
  logic [PW-1:0]        pop;

  always_comb begin
    logic [CW-1:0]        blk;
    logic [WORD_BITS-1:0] oob_v, force_v;
    logic [WORD_BITS:0]   gt;
    logic [WORD_BITS-1:0] win;
    logic                 cond;
    logic                 any_used;
    logic [IW-1:0]        msb;

    oob_v    = '0;
    force_v  = '0;
    rng_mask = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      blk         = base_q + CW'(k);
      oob_v[k]    = (blk >= CW'(BLOCK_TOTAL));
      force_v[k]  = (blk >= start_w) && (blk < force_hi);
      rng_mask[k] = (blk >= rng_lo) && (blk < rng_hi);
    end
    used_raw = word_i | oob_v;
    used_ff  = (word_i & ~force_v) | oob_v;

    // gt[d] tells whether the requested run is longer than d blocks.
    for (int d = 0; d <= WORD_BITS; d++) begin
      gt[d] = (need_ff > CW'(d));
    end

    // A run of need_ff free blocks ends at bit j when the window of the last
    // need_ff bits inside this word is free and, if the window reaches below
    // bit zero, the run carried in from lower words covers the rest.
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      win = '0;
      for (int k = 0; k <= j; k++) begin
        win[k] = gt[j-k];
      end
      cond = ((used_ff & win) == '0) &&
             (!gt[j+1] || ((run_q + CW'(j + 1)) >= need_ff));
      if (cond && !hit) begin
        hit     = 1'b1;
        hit_pos = IW'(j);
      end
    end

    // Free run leaving the top of this word.
    any_used = 1'b0;
    msb      = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (used_ff[k]) begin
        any_used = 1'b1;
        msb      = IW'(k);
      end
    end
    run_out = any_used ? (CW'(WORD_BITS - 1) - CW'(msb)) : (run_q + CW'(WORD_BITS));

    pop = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      pop = pop + PW'(!used_raw[k]);
    end
  end

  always_comb begin
    base_d     = base_q;
    run_d      = run_q;
    ff_found_d = ff_found_q;
    ff_at_d    = ff_at_q;
    clean_d    = clean_q;
    cnt_d      = cnt_q;
    if (ctrl_i.init) begin
      base_d     = '0;
      run_d      = '0;
      ff_found_d = 1'b0;
      ff_at_d    = '0;
      clean_d    = 1'b1;
      cnt_d      = '0;
    end else if (ctrl_i.word_valid) begin
      base_d  = base_q + CW'(WORD_BITS);
      run_d   = run_out;
      clean_d = clean_q && ((used_raw & rng_mask) == '0);
      cnt_d   = cnt_q + CW'(pop);
      if (!ff_found_q && (need_ff != '0) && hit) begin
        ff_found_d = 1'b1;
        ff_at_d    = base_q + CW'(hit_pos) + CW'(1) - need_ff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      run_q      <= '0;
      ff_found_q <= 1'b0;
      ff_at_q    <= '0;
      clean_q    <= 1'b0;
      cnt_q      <= '0;
    end else begin
      base_q     <= base_d;
      run_q      <= run_d;
      ff_found_q <= ff_found_d;
      ff_at_q    <= ff_at_d;
      clean_q    <= clean_d;
      cnt_q      <= cnt_d;
    end
  end

  // Result assembly: a load or read result, or a search or count result once the scan has seen every word.
  logic          start_ok, range_ok, keep_start;
  logic          found;
  logic [CW-1:0] idx;

  assign start_ok = (start_w < CW'(BLOCK_TOTAL));
  assign range_ok = clean_q && (rng_hi <= CW'(BLOCK_TOTAL)) && (need_w != '0);
  // A shrink or a same-size request keeps the file where it is.
  assign keep_start = start_ok && (need_w <= held_w);

  always_comb begin
    found       = 1'b0;
    idx         = '0;
    res_o       = '0;
    case (cmd_i.opcode)
      OP_LOAD: begin
        found = ctrl_i.widx_ok;
      end
      OP_READ: begin
        found = ctrl_i.widx_ok;
        if (ctrl_i.widx_ok) begin
          res_o.word_out = WDATA_W'(word_i);
        end
      end
      OP_FIRST: begin
        found = ff_found_q;
        idx   = ff_at_q;
      end
      OP_CONTIG: begin
        if (range_ok) begin
          found = 1'b1;
          idx   = start_w;
        end else begin
          found = ff_found_q;
          idx   = ff_at_q;
        end
      end
      OP_COUNT: begin
        found            = 1'b1;
        res_o.free_count = cnt_q[BLKCNT_W-1:0];
      end
      OP_GROW: begin
        if (keep_start || range_ok) begin
          found = 1'b1;
          idx   = start_w;
        end else begin
          found = ff_found_q;
          idx   = ff_at_q;
        end
      end
      default: begin
        found = 1'b0;
      end
    endcase
    res_o.found       = found;
    res_o.block_index = found ? idx[BLKIDX_W-1:0] : '0;
  end

endmodule

`default_nettype wire
